[src/mac_hash_device_id_learning_macros.svh]
// ----------------------------------------------------------------------------
// mac_hash_device_id_learning_macros.svh
// assertion macros shared by the address learning block
// ----------------------------------------------------------------------------
`ifndef MAC_HASH_DEVICE_ID_LEARNING_MACROS_SVH
`define MAC_HASH_DEVICE_ID_LEARNING_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked out of reset
`define MHDL_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, checked out of reset
`define MHDL_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define MHDL_ASSERT_SAME(label, clk, rstn, ante, cons)
`define MHDL_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

[src/mhdl_pkg.sv]
// ----------------------------------------------------------------------------
// mhdl_pkg
// types and constants of the mac hash device id learning block
// ----------------------------------------------------------------------------
package mhdl_pkg;

    localparam int MAC_W    = 48;
    localparam int LEN_W    = 8;
    localparam int HASH_W   = 32;
    localparam int ID_W     = 4;
    localparam int STATUS_W = 2;
    localparam int BYTE_W   = 8;

    localparam int MAC_BYTES   = 6;
    localparam int BYTE_CNT_W  = 3;
    localparam int DJB2_SHIFT  = 5;
    localparam logic [HASH_W-1:0] DJB2_START = 32'd5381;

    localparam logic [STATUS_W-1:0] STATUS_DROPPED = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_LEARNED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_KNOWN   = 2'd3;

    typedef struct packed {
        logic [MAC_W-1:0] mac_address;
        logic [LEN_W-1:0] frame_length;
    } in_beat_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     device_id;
        logic [HASH_W-1:0]   mac_hash;
    } out_beat_t;

endpackage

[src/mac_hash_device_id_learning.sv]
// ----------------------------------------------------------------------------
// mac_hash_device_id_learning
// learns sender mac addresses by djb2 hash and hands out device ids
// ----------------------------------------------------------------------------
// One beat at a time. After a beat is taken the mac is hashed one byte per
// cycle, then the learned hashes are read from the table memory one per
// cycle in id order. A beat with the wrong length skips the search, a hit
// ends the search at its id, and a miss reads every learned id. The result
// sits in an output register, and the next beat can be taken while it
// waits. Ids start at 1; once DEVICE_SLOTS - 1 ids are given out, misses
// report table full. The table needs no clearing after reset: only ids
// below the next free id are ever read.
module mac_hash_device_id_learning
    import mhdl_pkg::*;
#(
    parameter int DEVICE_SLOTS = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  in_beat_t         s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output out_beat_t        m_data,
    input  logic             cfg_we,
    input  logic [LEN_W-1:0] cfg_wdata
);

    `include "mac_hash_device_id_learning_macros.svh"

    localparam int IDX_W = $clog2(DEVICE_SLOTS);
    localparam int CNT_W = $clog2(DEVICE_SLOTS + 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_HASH   = 2'd1;
    localparam logic [1:0] ST_SEARCH = 2'd2;
    localparam logic [1:0] ST_RESULT = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [LEN_W-1:0]  exp_len_reg;
    logic              len_ok_reg;
    logic [CNT_W-1:0]  next_free_reg;
    logic [CNT_W-1:0]  srch_cnt_reg, srch_cnt_next;
    logic              rd_valid_reg, rd_valid_next;
    logic [IDX_W-1:0]  rd_idx_reg, rd_idx_next;
    logic [HASH_W-1:0] rd_data_reg;
    logic              hit_reg, hit_next;
    logic [IDX_W-1:0]  hit_id_reg, hit_id_next;
    logic              m_valid_reg;
    out_beat_t         m_data_reg;
    out_beat_t         out_next;

    logic [HASH_W-1:0] hash_mem [DEVICE_SLOTS];

    logic              in_fire;
    logic              hash_done;
    logic [HASH_W-1:0] hash_val;
    logic              issue;
    logic              match;
    logic              out_load;
    logic              table_full;
    logic              learn;
    logic [IDX_W-1:0]  id_sel;
    logic [IDX_W+ID_W-1:0] id_ext;

    assign s_ready = (state_reg == ST_IDLE);
    assign in_fire = s_valid && s_ready;

    mhdl_djb2 u_djb2 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (in_fire),
        .mac     (s_data.mac_address),
        .done    (hash_done),
        .hash    (hash_val)
    );

    assign issue      = (srch_cnt_reg < next_free_reg);
    assign match      = rd_valid_reg && (rd_data_reg == hash_val);
    assign out_load   = (state_reg == ST_RESULT) && (!m_valid_reg || m_ready);
    assign table_full = (next_free_reg == CNT_W'(DEVICE_SLOTS));
    assign learn      = out_load && len_ok_reg && !hit_reg && !table_full;

    always_comb begin
        state_next    = state_reg;
        srch_cnt_next = srch_cnt_reg;
        rd_valid_next = 1'b0;
        rd_idx_next   = rd_idx_reg;
        hit_next      = hit_reg;
        hit_id_next   = hit_id_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    state_next = ST_HASH;
                end
            end
            ST_HASH: begin
                if (hash_done) begin
                    hit_next      = 1'b0;
                    srch_cnt_next = CNT_W'(1);
                    state_next    = len_ok_reg ? ST_SEARCH : ST_RESULT;
                end
            end
            ST_SEARCH: begin
                rd_valid_next = issue;
                rd_idx_next   = srch_cnt_reg[IDX_W-1:0];
                if (issue) begin
                    srch_cnt_next = srch_cnt_reg + CNT_W'(1);
                end
                if (match) begin
                    hit_next      = 1'b1;
                    hit_id_next   = rd_idx_reg;
                    rd_valid_next = 1'b0;
                    state_next    = ST_RESULT;
                end else if (!issue && !rd_valid_reg) begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        id_sel = '0;
        out_next.status = STATUS_DROPPED;
        if (len_ok_reg) begin
            if (hit_reg) begin
                out_next.status = STATUS_KNOWN;
                id_sel          = hit_id_reg;
            end else if (table_full) begin
                out_next.status = STATUS_FULL;
            end else begin
                out_next.status = STATUS_LEARNED;
                id_sel          = next_free_reg[IDX_W-1:0];
            end
        end
        id_ext             = {{ID_W{1'b0}}, id_sel};
        out_next.device_id = id_ext[ID_W-1:0];
        out_next.mac_hash  = hash_val;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            exp_len_reg   <= '0;
            next_free_reg <= CNT_W'(1);
            rd_valid_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rd_valid_reg <= rd_valid_next;
            if (cfg_we) begin
                exp_len_reg <= cfg_wdata;
            end
            if (learn) begin
                next_free_reg <= next_free_reg + CNT_W'(1);
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            len_ok_reg <= (s_data.frame_length == exp_len_reg);
        end
        srch_cnt_reg <= srch_cnt_next;
        rd_idx_reg   <= rd_idx_next;
        hit_reg      <= hit_next;
        hit_id_reg   <= hit_id_next;
        if (out_load) begin
            m_data_reg <= out_next;
        end
    end

    // hash table
    always_ff @(posedge aclk) begin
        if (learn) begin
            hash_mem[next_free_reg[IDX_W-1:0]] <= hash_val;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= hash_mem[srch_cnt_reg[IDX_W-1:0]];
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `MHDL_ASSERT_SAME(a_free_range, aclk, aresetn, 1'b1,
                      (next_free_reg >= CNT_W'(1)) && (next_free_reg <= CNT_W'(DEVICE_SLOTS)))
    `MHDL_ASSERT_NEXT(a_learn_bumps_free, aclk, aresetn, learn,
                      next_free_reg == $past(next_free_reg) + CNT_W'(1))
    `MHDL_ASSERT_SAME(a_search_bound, aclk, aresetn, state_reg == ST_SEARCH,
                      srch_cnt_reg <= next_free_reg)
    `MHDL_ASSERT_NEXT(a_no_accept_busy, aclk, aresetn, in_fire, !s_ready)

endmodule

[src/mhdl_djb2.sv]
// ----------------------------------------------------------------------------
// mhdl_djb2
// byte-serial djb2 hash of a 48-bit mac address, first byte first
// ----------------------------------------------------------------------------
module mhdl_djb2
    import mhdl_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [MAC_W-1:0]  mac,
    output logic              done,
    output logic [HASH_W-1:0] hash
);

    `include "mac_hash_device_id_learning_macros.svh"

    logic [MAC_W-1:0]      mac_reg;
    logic [HASH_W-1:0]     hash_reg;
    logic [BYTE_CNT_W-1:0] cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic [HASH_W-1:0]     hash_step;
    logic                  last_byte;

    assign hash_step = (hash_reg << DJB2_SHIFT) + hash_reg
                     + {{(HASH_W-BYTE_W){1'b0}}, mac_reg[MAC_W-1 -: BYTE_W]};
    assign last_byte = (cnt_reg == BYTE_CNT_W'(MAC_BYTES - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + BYTE_CNT_W'(1);
                if (last_byte) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            mac_reg  <= mac;
            hash_reg <= DJB2_START;
        end else if (busy_reg) begin
            mac_reg  <= mac_reg << BYTE_W;
            hash_reg <= hash_step;
        end
    end

    assign done = done_reg;
    assign hash = hash_reg;

    `MHDL_ASSERT_NEXT(a_start_no_done, aclk, aresetn, start, !done_reg)
    `MHDL_ASSERT_SAME(a_cnt_range, aclk, aresetn, busy_reg,
                      cnt_reg <= BYTE_CNT_W'(MAC_BYTES - 1))
    `MHDL_ASSERT_NEXT(a_done_pulse, aclk, aresetn, done_reg, !done_reg)

endmodule

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// testbench of the mac hash device id learning block: frames are sent over a
// valid/ready channel with random idle gaps on both sides, each result is
// compared field by field with a local predictor of the hash table, and the
// frame length register is changed between phases, its extremes included
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
    import mhdl_pkg::*;

    localparam int SLOTS = 16;

    logic             aclk;
    logic             aresetn;
    logic             s_valid;
    logic             s_ready;
    in_beat_t         s_data;
    logic             m_valid;
    logic             m_ready;
    out_beat_t        m_data;
    logic             cfg_we;
    logic [LEN_W-1:0] cfg_wdata;

    mac_hash_device_id_learning #(
        .DEVICE_SLOTS(SLOTS)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // predictor copy of the table
    logic [HASH_W-1:0] id_hash [SLOTS];
    logic              id_used [SLOTS];
    int                next_id;
    logic [LEN_W-1:0]  cur_length;

    out_beat_t        pending_results [$];
    logic [MAC_W-1:0] learned_macs [$];

    int error_count;
    int frames_sent;
    int length_writes;
    int status_seen [4];
    int tx_max_gap;
    int rx_max_gap;
    int rx_hold;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5ms;
        $display("TB_ERROR");
        $finish;
    end

    function automatic logic [HASH_W-1:0] djb2_of(logic [MAC_W-1:0] mac);
        logic [HASH_W-1:0] h;
        h = DJB2_START;
        for (int i = 0; i < MAC_BYTES; i++) begin
            h = (h << DJB2_SHIFT) + h + {24'd0, mac[MAC_W-1-BYTE_W*i -: BYTE_W]};
        end
        return h;
    endfunction

    function automatic out_beat_t learn_or_match(in_beat_t b);
        out_beat_t r;
        int        hit_id;
        r.mac_hash  = djb2_of(b.mac_address);
        r.device_id = '0;
        hit_id      = 0;
        if (b.frame_length != cur_length) begin
            r.status = STATUS_DROPPED;
        end else begin
            for (int k = SLOTS - 1; k >= 1; k--) begin
                if (id_used[k] && id_hash[k] == r.mac_hash) hit_id = k;
            end
            if (hit_id != 0) begin
                r.status    = STATUS_KNOWN;
                r.device_id = hit_id[ID_W-1:0];
            end else if (next_id >= SLOTS) begin
                r.status = STATUS_FULL;
            end else begin
                r.status         = STATUS_LEARNED;
                r.device_id      = next_id[ID_W-1:0];
                id_hash[next_id] = r.mac_hash;
                id_used[next_id] = 1'b1;
                next_id          = next_id + 1;
                learned_macs.push_back(b.mac_address);
            end
        end
        return r;
    endfunction

    // result check and prediction of accepted beats
    always @(posedge aclk) begin
        out_beat_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    $error("result beat with nothing expected: status %0d id %0d hash %h",
                           m_data.status, m_data.device_id, m_data.mac_hash);
                    error_count++;
                end else begin
                    want = pending_results.pop_front();
                    status_seen[want.status]++;
                    if (m_data.status !== want.status) begin
                        $error("status mismatch: expected %0d, got %0d",
                               want.status, m_data.status);
                        error_count++;
                    end
                    if (m_data.device_id !== want.device_id) begin
                        $error("device_id mismatch: expected %0d, got %0d",
                               want.device_id, m_data.device_id);
                        error_count++;
                    end
                    if (m_data.mac_hash !== want.mac_hash) begin
                        $error("mac_hash mismatch: expected %h, got %h",
                               want.mac_hash, m_data.mac_hash);
                        error_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                pending_results.push_back(learn_or_match(s_data));
            end
        end
    end

    // result side: random stall per beat, long hold on request
    initial begin
        int stall;
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = $urandom_range(0, rx_max_gap);
            if (rx_hold > 0) begin
                stall   = rx_hold;
                rx_hold = 0;
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    task automatic send_frame(logic [MAC_W-1:0] mac, logic [LEN_W-1:0] len);
        int gap;
        gap = $urandom_range(0, tx_max_gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid             <= 1'b1;
        s_data.mac_address  <= mac;
        s_data.frame_length <= len;
        do @(posedge aclk); while (!s_ready);
        frames_sent++;
    endtask

    task automatic wait_results_done();
        s_valid <= 1'b0;
        // let the last accepted beat reach the expected queue
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic write_expected_length(logic [LEN_W-1:0] len);
        wait_results_done();
        repeat (SLOTS + 12) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= len;
        @(posedge aclk);
        cfg_we     <= 1'b0;
        cur_length  = len;
        length_writes++;
    endtask

    function automatic logic [MAC_W-1:0] random_mac();
        return MAC_W'({$urandom, $urandom});
    endfunction

    task automatic test_length_check();
        send_frame('0, 8'd0);
        send_frame({MAC_W{1'b1}}, 8'd255);
        write_expected_length(8'd255);
        send_frame({MAC_W{1'b1}}, 8'd255);
        send_frame('0, 8'd255);
        send_frame(random_mac(), 8'd0);
        send_frame(random_mac(), 8'd254);
    endtask

    task automatic test_learn_and_hit();
        write_expected_length(8'd64);
        send_frame(48'hAAAA_AAAA_AAAA, 8'd64);
        send_frame(48'h5555_5555_5555, 8'd64);
        send_frame(48'h0123_4567_89AB, 8'd64);
        send_frame(48'h5555_5555_5555, 8'd64);
        // same djb2 hash as 0123456789ab: last two bytes traded by 33
        send_frame(48'h0123_4567_8A8A, 8'd64);
        send_frame({MAC_W{1'b1}}, 8'd64);
    endtask

    task automatic test_table_full();
        while (next_id < SLOTS) begin
            send_frame(random_mac(), 8'd64);
            wait_results_done();
        end
        send_frame(random_mac(), 8'd64);
        send_frame(learned_macs[learned_macs.size() - 1], 8'd64);
        send_frame(learned_macs[0], 8'd64);
    endtask

    task automatic send_random_frame();
        logic [LEN_W-1:0] len;
        logic [MAC_W-1:0] mac;
        len = cur_length;
        if ($urandom_range(0, 99) < 15) len = cur_length ^ 8'($urandom_range(1, 255));
        if ($urandom_range(0, 99) < 75 && learned_macs.size() > 0) begin
            mac = learned_macs[$urandom_range(0, learned_macs.size() - 1)];
        end else begin
            mac = random_mac();
        end
        send_frame(mac, len);
    endtask

    task automatic test_output_backpressure();
        int saved_gap;
        saved_gap  = tx_max_gap;
        tx_max_gap = 0;
        rx_hold    = 300;
        repeat (40) send_random_frame();
        tx_max_gap = saved_gap;
        wait_results_done();
    endtask

    task automatic test_idle_drain();
        repeat (10) send_random_frame();
        wait_results_done();
        repeat (10) send_random_frame();
        wait_results_done();
    endtask

    task automatic test_random_traffic(int n_items);
        logic [LEN_W-1:0] len_plan [6];
        len_plan = '{8'd0, 8'd255, 8'd1, 8'd128, 8'($urandom), 8'($urandom)};
        for (int p = 0; p < 6; p++) begin
            write_expected_length(len_plan[p]);
            tx_max_gap = (p % 3 == 2) ? 0 : 8;
            rx_max_gap = (p % 3 == 2) ? 0 : 8;
            repeat (n_items / 6) send_random_frame();
        end
        tx_max_gap = 8;
        rx_max_gap = 8;
    endtask

    initial begin
        int guard;
        aresetn    <= 1'b0;
        s_valid    <= 1'b0;
        s_data     <= '0;
        cfg_we     <= 1'b0;
        cfg_wdata  <= '0;
        tx_max_gap  = 8;
        rx_max_gap  = 8;
        rx_hold     = 0;
        error_count = 0;
        cur_length  = '0;
        next_id     = 1;
        for (int k = 0; k < SLOTS; k++) begin
            id_hash[k] = '0;
            id_used[k] = 1'b0;
        end
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_length_check();
        test_learn_and_hit();
        test_table_full();
        test_output_backpressure();
        test_idle_drain();
        test_random_traffic(570);

        s_valid <= 1'b0;
        @(posedge aclk);
        guard = 0;
        while (pending_results.size() != 0 && guard < 20000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (SLOTS + 20) @(posedge aclk);
        if (pending_results.size() != 0) begin
            $error("%0d result beats never arrived", pending_results.size());
            error_count++;
        end

        $display("frames: %0d sent, %0d dropped, %0d learned, %0d table full, %0d known",
                 frames_sent, status_seen[STATUS_DROPPED], status_seen[STATUS_LEARNED],
                 status_seen[STATUS_FULL], status_seen[STATUS_KNOWN]);
        $display("length register written %0d times, long output hold and idle drains run",
                 length_writes);
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+src
src/mhdl_pkg.sv
src/mhdl_djb2.sv
src/mac_hash_device_id_learning.sv
test/tb_top.sv
